// ===== design/bitblt_pkg.sv =====
// Shared types and constants for the one-bit rectangle blit unit.
// No dependencies; every other file of the block refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package bitblt_pkg;

   // Field widths of the request and response beats
   localparam int unsigned MODE_W   = 2;
   localparam int unsigned BADDR_W  = 14;
   localparam int unsigned DATA_W   = 8;
   localparam int unsigned XPOS_W   = 9;
   localparam int unsigned YPOS_W   = 8;

   // Default screen geometry
   localparam int unsigned SCREEN_WIDTH_PX_DEF    = 400;
   localparam int unsigned SCREEN_HEIGHT_ROWS_DEF = 240;
   localparam int unsigned ROW_STRIDE_BYTES_DEF   = 52;

   // Width of computed pixel byte addresses: a row below 256 times a stride of
   // at most 512 plus a column byte below 128 stays under 2**20
   localparam int unsigned WIDE_AW = 20;

   // Leftmost pixel of a byte sits in its msb
   localparam logic [DATA_W-1:0] PIXEL_MSB_MASK = 8'h80;
   localparam logic [2:0]        BIT_IDX_MAX    = 3'd7;

   // Request operation codes
   typedef enum logic [MODE_W-1:0] {
      MODE_WR_SRC = 2'd0,
      MODE_WR_DST = 2'd1,
      MODE_RD_DST = 2'd2,
      MODE_COPY   = 2'd3
   } mode_type;

endpackage

`default_nettype wire

// ===== design/bitblt_ifs.sv =====
// Valid/ready channel interfaces for request and response beats of the blit unit.
// Depends on bitblt_pkg for field widths and the operation code type.
`timescale 1ns / 1ps
`default_nettype none

interface bitblt_req_if;
   logic                                valid;
   logic                                ready;
   bitblt_pkg::mode_type                mode;
   logic [bitblt_pkg::BADDR_W-1:0]      byte_address;
   logic [bitblt_pkg::DATA_W-1:0]       write_data;
   logic [bitblt_pkg::XPOS_W-1:0]       src_x;
   logic [bitblt_pkg::YPOS_W-1:0]       src_y;
   logic [bitblt_pkg::XPOS_W-1:0]       rect_width;
   logic [bitblt_pkg::YPOS_W-1:0]       rect_height;
   logic [bitblt_pkg::XPOS_W-1:0]       dst_x;
   logic [bitblt_pkg::YPOS_W-1:0]       dst_y;

   modport source (
      output valid, mode, byte_address, write_data, src_x, src_y,
             rect_width, rect_height, dst_x, dst_y,
      input  ready
   );
   modport sink (
      input  valid, mode, byte_address, write_data, src_x, src_y,
             rect_width, rect_height, dst_x, dst_y,
      output ready
   );
endinterface

interface bitblt_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [bitblt_pkg::DATA_W-1:0]       read_data;
   logic                                status;

   modport source (
      output valid, read_data, status,
      input  ready
   );
   modport sink (
      input  valid, read_data, status,
      output ready
   );
endinterface

`default_nettype wire

// ===== design/one_bit_rectangle_blit_unit.sv =====
// Blitter for packed 1-bit-per-pixel frames, msb leftmost.
//
// Channels: req (sink) carries bus writes to the source or destination store,
// bus reads of the destination store and rectangle copies; rsp (source)
// returns exactly one beat per request with read_data and status.
// One request is worked on at a time. The response sits in an output
// register, so req is ready again while an earlier response still waits.
// A store write loads its response into the output register at the accept
// edge when rsp is free, and req stays ready; a read first passes the
// ST_BUS_READ state, for the registered read port of the destination store.
// A copy streams one pixel per cycle through a read stage and a
// modify/write stage sharing the destination store, with forwarding of the
// previous write; after the last pixel it answers from the ST_DRAIN state.
// A rejected or empty rectangle answers like a write, a rejected one with status set.
// Reset clears the control path only; the frame stores keep their content
// and must be written before they are read.
// A stalled rsp holds the finished response; the unit then waits before
// loading the next one.
// Depends on bitblt_pkg and the interfaces in bitblt_ifs.sv.
`timescale 1ns / 1ps
`default_nettype none

module one_bit_rectangle_blit_unit #(
   parameter int unsigned SCREEN_WIDTH_PX    = bitblt_pkg::SCREEN_WIDTH_PX_DEF,
   parameter int unsigned SCREEN_HEIGHT_ROWS = bitblt_pkg::SCREEN_HEIGHT_ROWS_DEF,
   parameter int unsigned ROW_STRIDE_BYTES   = bitblt_pkg::ROW_STRIDE_BYTES_DEF
) (
   input  wire logic          clock,
   input  wire logic          reset,
   bitblt_req_if.sink         req,
   bitblt_rsp_if.source       rsp
);

   localparam int unsigned STORE_BYTES = ROW_STRIDE_BYTES * SCREEN_HEIGHT_ROWS;
   localparam int unsigned MEM_AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
   localparam int unsigned WA = (MEM_AW > bitblt_pkg::WIDE_AW) ? MEM_AW
                                                               : bitblt_pkg::WIDE_AW;
   localparam int unsigned DW = bitblt_pkg::DATA_W;
   localparam int unsigned XW = bitblt_pkg::XPOS_W;
   localparam int unsigned YW = bitblt_pkg::YPOS_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BUS_READ,
      ST_COPY,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   // Control state
   state_type          state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               b_valid_ff, b_valid_in;
   logic               fwd_valid_ff, fwd_valid_in;

   // Payload registers
   logic [DW-1:0]      rsp_data_ff, rsp_data_in;
   logic               rsp_status_ff, rsp_status_in;
   logic [DW-1:0]      res_data_ff, res_data_in;
   logic               res_status_ff, res_status_in;
   logic               rd_ok_ff, rd_ok_in;
   logic [XW-1:0]      sx_ff, sx_in, dx_ff, dx_in, w_ff, w_in, col_ff, col_in;
   logic [YW-1:0]      h_ff, h_in, row_ff, row_in;
   logic [WA-1:0]      src_base_ff, src_base_in, dst_base_ff, dst_base_in;
   logic               b_sa_ok_ff, b_sa_ok_in, b_da_ok_ff, b_da_ok_in;
   logic [2:0]         b_sbit_ff, b_sbit_in, b_dbit_ff, b_dbit_in;
   logic [MEM_AW-1:0]  b_da_ff, b_da_in;
   logic [MEM_AW-1:0]  fwd_addr_ff, fwd_addr_in;
   logic [DW-1:0]      fwd_data_ff, fwd_data_in;

   // Frame stores
   logic [DW-1:0]      src_mem [STORE_BYTES];
   logic [DW-1:0]      dst_mem [STORE_BYTES];
   logic [DW-1:0]      src_q, dst_q;
   logic               src_we, dst_we;
   logic [MEM_AW-1:0]  src_waddr, src_raddr, dst_waddr, dst_raddr;
   logic [DW-1:0]      src_wdata, dst_wdata;

   // Request side decode
   logic               req_fire, slot_free;
   logic [WA-1:0]      bus_addr;
   logic               bus_ok;
   logic [XW:0]        x_span_src, x_span_dst;
   logic [YW:0]        y_span_src, y_span_dst;
   logic               rect_fits;

   // Read stage of the copy
   logic [XW:0]        sxp, dxp;
   logic [WA-1:0]      sa, da;
   logic               last_col, last_row;

   // Modify stage of the copy
   logic               src_bit;
   logic [DW-1:0]      old_byte, dmask, new_byte;

   // Completion of the current item
   logic               done;
   logic [DW-1:0]      done_data;
   logic               done_status;

   assign req.ready     = (state_ff == ST_IDLE);
   assign req_fire      = req.valid && req.ready;
   assign slot_free     = !rsp_valid_ff || rsp.ready;
   assign rsp.valid     = rsp_valid_ff;
   assign rsp.read_data = rsp_data_ff;
   assign rsp.status    = rsp_status_ff;

   // Decode bus address and rectangle bounds
   assign bus_addr   = WA'(req.byte_address);
   assign bus_ok     = 32'(bus_addr) < STORE_BYTES;
   assign x_span_src = {1'b0, req.src_x} + {1'b0, req.rect_width};
   assign x_span_dst = {1'b0, req.dst_x} + {1'b0, req.rect_width};
   assign y_span_src = {1'b0, req.src_y} + {1'b0, req.rect_height};
   assign y_span_dst = {1'b0, req.dst_y} + {1'b0, req.rect_height};
   assign rect_fits  = (32'(x_span_src) <= SCREEN_WIDTH_PX)
                    && (32'(x_span_dst) <= SCREEN_WIDTH_PX)
                    && (32'(y_span_src) <= SCREEN_HEIGHT_ROWS)
                    && (32'(y_span_dst) <= SCREEN_HEIGHT_ROWS);

   // Address the current pixel of the copy
   assign sxp      = {1'b0, sx_ff} + {1'b0, col_ff};
   assign dxp      = {1'b0, dx_ff} + {1'b0, col_ff};
   assign sa       = src_base_ff + WA'(sxp[XW:3]);
   assign da       = dst_base_ff + WA'(dxp[XW:3]);
   assign last_col = (col_ff == w_ff - XW'(1));
   assign last_row = (row_ff == h_ff - YW'(1));

   // Merge the source pixel into the destination byte, forwarding last write
   assign src_bit  = b_sa_ok_ff && src_q[bitblt_pkg::BIT_IDX_MAX - b_sbit_ff];
   assign old_byte = (fwd_valid_ff && (fwd_addr_ff == b_da_ff)) ? fwd_data_ff : dst_q;
   assign dmask    = bitblt_pkg::PIXEL_MSB_MASK >> b_dbit_ff;
   assign new_byte = src_bit ? (old_byte | dmask) : (old_byte & ~dmask);

   // Steer the store ports
   always_comb begin
      src_we    = req_fire && (req.mode == bitblt_pkg::MODE_WR_SRC) && bus_ok;
      src_waddr = bus_addr[MEM_AW-1:0];
      src_wdata = req.write_data;
      src_raddr = sa[MEM_AW-1:0];
      if (b_valid_ff) begin
         dst_we    = b_da_ok_ff;
         dst_waddr = b_da_ff;
         dst_wdata = new_byte;
      end else begin
         dst_we    = req_fire && (req.mode == bitblt_pkg::MODE_WR_DST) && bus_ok;
         dst_waddr = bus_addr[MEM_AW-1:0];
         dst_wdata = req.write_data;
      end
      dst_raddr = (state_ff == ST_COPY) ? da[MEM_AW-1:0] : bus_addr[MEM_AW-1:0];
   end

   // Sequence items and copy pixels
   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      res_data_in   = res_data_ff;
      res_status_in = res_status_ff;
      rd_ok_in      = rd_ok_ff;
      sx_in         = sx_ff;
      dx_in         = dx_ff;
      w_in          = w_ff;
      h_in          = h_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      src_base_in   = src_base_ff;
      dst_base_in   = dst_base_ff;
      done          = 1'b0;
      done_data     = '0;
      done_status   = 1'b0;

      // read stage feeds the modify stage while copying
      b_valid_in = (state_ff == ST_COPY);
      b_sa_ok_in = 32'(sa) < STORE_BYTES;
      b_da_ok_in = 32'(da) < STORE_BYTES;
      b_sbit_in  = sxp[2:0];
      b_dbit_in  = dxp[2:0];
      b_da_in    = da[MEM_AW-1:0];

      // remember the byte just written for the next pixel
      fwd_valid_in = b_valid_ff && b_da_ok_ff;
      fwd_addr_in  = b_da_ff;
      fwd_data_in  = new_byte;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               unique case (req.mode)
                  bitblt_pkg::MODE_WR_SRC,
                  bitblt_pkg::MODE_WR_DST: begin
                     done = 1'b1;
                  end
                  bitblt_pkg::MODE_RD_DST: begin
                     rd_ok_in = bus_ok;
                     state_in = ST_BUS_READ;
                  end
                  bitblt_pkg::MODE_COPY: begin
                     if (!rect_fits) begin
                        done        = 1'b1;
                        done_status = 1'b1;
                     end else if ((req.rect_width == '0) || (req.rect_height == '0)) begin
                        done = 1'b1;
                     end else begin
                        sx_in       = req.src_x;
                        dx_in       = req.dst_x;
                        w_in        = req.rect_width;
                        h_in        = req.rect_height;
                        col_in      = '0;
                        row_in      = '0;
                        src_base_in = WA'(req.src_y) * WA'(ROW_STRIDE_BYTES);
                        dst_base_in = WA'(req.dst_y) * WA'(ROW_STRIDE_BYTES);
                        state_in    = ST_COPY;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_BUS_READ: begin
            done      = 1'b1;
            done_data = rd_ok_ff ? dst_q : '0;
         end
         ST_COPY: begin
            // advance column, wrap to the next row at its end
            if (last_col) begin
               col_in      = '0;
               row_in      = row_ff + YW'(1);
               src_base_in = src_base_ff + WA'(ROW_STRIDE_BYTES);
               dst_base_in = dst_base_ff + WA'(ROW_STRIDE_BYTES);
               if (last_row) begin
                  state_in = ST_DRAIN;
               end
            end else begin
               col_in = col_ff + XW'(1);
            end
         end
         ST_DRAIN: begin
            done = 1'b1;
         end
         ST_FINISH: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = res_data_ff;
               rsp_status_in = res_status_ff;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // hand the result to the output register, or hold it until rsp drains
      if (done) begin
         if (slot_free) begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = done_data;
            rsp_status_in = done_status;
            state_in      = ST_IDLE;
         end else begin
            res_data_in   = done_data;
            res_status_in = done_status;
            state_in      = ST_FINISH;
         end
      end
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         b_valid_ff   <= 1'b0;
         fwd_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         b_valid_ff   <= b_valid_in;
         fwd_valid_ff <= fwd_valid_in;
      end
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
      res_data_ff   <= res_data_in;
      res_status_ff <= res_status_in;
      rd_ok_ff      <= rd_ok_in;
      sx_ff         <= sx_in;
      dx_ff         <= dx_in;
      w_ff          <= w_in;
      h_ff          <= h_in;
      col_ff        <= col_in;
      row_ff        <= row_in;
      src_base_ff   <= src_base_in;
      dst_base_ff   <= dst_base_in;
      b_sa_ok_ff    <= b_sa_ok_in;
      b_da_ok_ff    <= b_da_ok_in;
      b_sbit_ff     <= b_sbit_in;
      b_dbit_ff     <= b_dbit_in;
      b_da_ff       <= b_da_in;
      fwd_addr_ff   <= fwd_addr_in;
      fwd_data_ff   <= fwd_data_in;
   end

   // Source frame store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (src_we) begin
         src_mem[src_waddr] <= src_wdata;
      end
      src_q <= src_mem[src_raddr];
   end

   // Destination frame store: read returns the byte before a same-cycle write
   always_ff @(posedge clock) begin
      if (dst_we) begin
         dst_mem[dst_waddr] <= dst_wdata;
      end
      dst_q <= dst_mem[dst_raddr];
   end

endmodule

`default_nettype wire
